// File: sv/qlgs_pkg.sv
// ----------------------------------------------------------------------------
// qlgs_pkg
// Shared types and constants of the Q-learning graph step engine.
// ----------------------------------------------------------------------------
package qlgs_pkg;

  localparam int STATE_W    = 4;
  localparam int NUM_STATES = 1 << STATE_W;

  localparam int Q_WIDTH_DEF        = 32;
  localparam int RATE_FRAC_BITS_DEF = 8;

  localparam int RAND_W     = 32;
  localparam int QOUT_W     = 32;
  localparam int IDX_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q_FRAC     = 8;

  typedef enum logic [1:0] {
    ACT_SET_EDGE = 2'd0,
    ACT_START    = 2'd1,
    ACT_STEP     = 2'd2,
    ACT_READ_Q   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_LEARNING_RATE = 2'd0,
    CFG_DISCOUNT_RATE = 2'd1,
    CFG_GOAL_STATE    = 2'd2,
    CFG_REWARD_VALUE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    QA_SCAN = 2'd0,
    QA_SN   = 2'd1,
    QA_RQ   = 2'd2
  } qaddr_sel_t;

  typedef struct packed {
    logic       clr_wr;
    logic       load_in;
    logic       erd;
    logic       erd_src;
    logic       ewr;
    logic       row_load;
    logic       j_clr;
    logic       cnt_step;
    logic       mod_start;
    logic       pick_step;
    logic       max_issue;
    logic       q_rd;
    qaddr_sel_t q_sel;
    logic       mul1;
    logic       tgt;
    logic       diff;
    logic       mul2;
    logic       upd;
    logic       set_start;
    logic       set_err;
    logic       set_rq;
    logic       out_load;
  } qlgs_cmd_t;

  typedef struct packed {
    logic    clr_last;
    action_t act;
    logic    j_last;
    logic    cnt_zero;
    logic    mod_done;
    logic    hit;
    logic    out_free;
  } qlgs_sts_t;

endpackage

// File: sv/q_learning_graph_step_top.sv
// ----------------------------------------------------------------------------
// q_learning_graph_step_top
// Tabular Q-learning engine over a directed graph of states.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one command beat: set_edge,
// start_episode, step or read_q. Every beat yields exactly one result beat on
// the output channel (out_valid/out_ready) with the present state, a Q value
// and the episode_done and no_move_error flags. The configuration channel
// (cfg_valid/cfg_ready) writes learning rate, discount rate, goal state and
// reward; it is always ready and should be used only while the engine idles.
// One beat is handled at a time. set_edge, start_episode and read_q go from
// decode through their own action state to the result state. A step without
// an allowed move ends after the pass that counts moves, with no_move_error
// set. Any other step makes one pass over the edge row to count moves, takes
// the bit-serial remainder of the random value by that count, makes a pass
// to find the chosen move and a pass over the Q row for the maximum, then
// does two registered multiplies. After reset a clearing pass zeroes the
// edge and Q memories; in_ready stays low until it ends. A stalled receiver
// holds the result in the output register; the next beat is accepted and
// worked on, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module q_learning_graph_step_top #(
  parameter int Q_WIDTH        = qlgs_pkg::Q_WIDTH_DEF,
  parameter int RATE_FRAC_BITS = qlgs_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic [qlgs_pkg::STATE_W-1:0]        src_state,
  input  logic [qlgs_pkg::STATE_W-1:0]        dst_state,
  input  logic [qlgs_pkg::RAND_W-1:0]         rand_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [qlgs_pkg::STATE_W-1:0]        cur_state,
  output logic [qlgs_pkg::QOUT_W-1:0]         q_value,
  output logic                                episode_done,
  output logic                                no_move_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qlgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qlgs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  qlgs_pkg::qlgs_cmd_t cmd;
  qlgs_pkg::qlgs_sts_t sts;

  assign cfg_ready = 1'b1;

  qlgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qlgs_datapath #(
    .Q_WIDTH        (Q_WIDTH),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .src_state     (src_state),
    .dst_state     (dst_state),
    .rand_value    (rand_value),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cur_state     (cur_state),
    .q_value       (q_value),
    .episode_done  (episode_done),
    .no_move_error (no_move_error)
  );

endmodule

// File: sv/qlgs_mod_unit.sv
// ----------------------------------------------------------------------------
// qlgs_mod_unit
// Bit-serial restoring remainder of a 32-bit value by a divisor up to 64.
// ----------------------------------------------------------------------------
module qlgs_mod_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [qlgs_pkg::RAND_W-1:0]       dividend,
  input  logic [qlgs_pkg::IDX_W-1:0]        divisor,
  output logic                              done,
  output logic [qlgs_pkg::IDX_W-1:0]        rem
);

  localparam int DW = qlgs_pkg::RAND_W;
  localparam int IX = qlgs_pkg::IDX_W;

  logic          busy;
  logic [4:0]    bitcnt;
  logic [DW-1:0] dvd;
  logic [IX-1:0] div;
  logic [IX-1:0] sh;

  assign sh = {rem[IX-2:0], dvd[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      bitcnt <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      done   <= 1'b0;
      bitcnt <= 5'(DW - 1);
    end else if (busy) begin
      bitcnt <= bitcnt - 5'd1;
      if (bitcnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      rem <= (sh >= div) ? (sh - div) : sh;
    end
  end

endmodule

// File: sv/qlgs_ctrl.sv
// ----------------------------------------------------------------------------
// qlgs_ctrl
// Sequencer of the engine: clearing pass, item decode and step micro-steps.
// ----------------------------------------------------------------------------
module qlgs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  qlgs_pkg::qlgs_sts_t sts,
  output qlgs_pkg::qlgs_cmd_t cmd
);

  typedef enum logic [19:0] {
    S_CLEAR     = 20'h00001,
    S_IDLE      = 20'h00002,
    S_DECODE    = 20'h00004,
    S_EDGE_WR   = 20'h00008,
    S_ROW_LOAD  = 20'h00010,
    S_COUNT     = 20'h00020,
    S_CHK       = 20'h00040,
    S_MOD_WAIT  = 20'h00080,
    S_START_SET = 20'h00100,
    S_PICK      = 20'h00200,
    S_MAX_SCAN  = 20'h00400,
    S_MAX_TAIL  = 20'h00800,
    S_Q_RD      = 20'h01000,
    S_MUL1      = 20'h02000,
    S_TGT       = 20'h04000,
    S_DIFF      = 20'h08000,
    S_MUL2      = 20'h10000,
    S_UPD       = 20'h20000,
    S_RQ_GET    = 20'h40000,
    S_RES       = 20'h80000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.q_sel  = qlgs_pkg::QA_SCAN;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.act)
          qlgs_pkg::ACT_SET_EDGE: begin
            cmd.erd     = 1'b1;
            cmd.erd_src = 1'b1;
            state_next  = S_EDGE_WR;
          end
          qlgs_pkg::ACT_START: begin
            state_next = S_START_SET;
          end
          qlgs_pkg::ACT_STEP: begin
            cmd.erd    = 1'b1;
            state_next = S_ROW_LOAD;
          end
          default: begin
            cmd.q_rd   = 1'b1;
            cmd.q_sel  = qlgs_pkg::QA_RQ;
            state_next = S_RQ_GET;
          end
        endcase
      end
      S_EDGE_WR: begin
        cmd.ewr    = 1'b1;
        state_next = S_RES;
      end
      S_ROW_LOAD: begin
        cmd.row_load = 1'b1;
        cmd.j_clr    = 1'b1;
        state_next   = S_COUNT;
      end
      S_COUNT: begin
        cmd.cnt_step = 1'b1;
        if (sts.j_last) state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.cnt_zero) begin
          cmd.set_err = 1'b1;
          state_next  = S_RES;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD_WAIT;
        end
      end
      S_MOD_WAIT: begin
        if (sts.mod_done) begin
          cmd.j_clr  = 1'b1;
          state_next = S_PICK;
        end
      end
      S_START_SET: begin
        cmd.set_start = 1'b1;
        state_next    = S_RES;
      end
      S_PICK: begin
        cmd.pick_step = 1'b1;
        if (sts.hit) begin
          cmd.j_clr  = 1'b1;
          state_next = S_MAX_SCAN;
        end
      end
      S_MAX_SCAN: begin
        cmd.max_issue = 1'b1;
        cmd.q_rd      = 1'b1;
        if (sts.j_last) state_next = S_MAX_TAIL;
      end
      S_MAX_TAIL: state_next = S_Q_RD;
      S_Q_RD: begin
        cmd.q_rd   = 1'b1;
        cmd.q_sel  = qlgs_pkg::QA_SN;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_TGT;
      end
      S_TGT: begin
        cmd.tgt    = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_RES;
      end
      S_RQ_GET: begin
        cmd.set_rq = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

`ifndef SYNTHESIS
  a_clear_after_reset: assert property (@(posedge clk) $fell(rst) |-> state == S_CLEAR)
    else $error("clearing pass does not follow reset");
  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && sts.j_last) |-> sts.hit)
    else $error("move choice ran past the last allowed move");
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DECODE)
    else $error("accepted beat not decoded");
`endif

endmodule

// File: sv/qlgs_datapath.sv
// ----------------------------------------------------------------------------
// qlgs_datapath
// Edge and Q memories, scan counters, fixed-point update and output register.
// ----------------------------------------------------------------------------
module qlgs_datapath #(
  parameter int Q_WIDTH        = qlgs_pkg::Q_WIDTH_DEF,
  parameter int RATE_FRAC_BITS = qlgs_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  qlgs_pkg::qlgs_cmd_t                 cmd,
  output qlgs_pkg::qlgs_sts_t                 sts,
  input  logic [1:0]                          action,
  input  logic [qlgs_pkg::STATE_W-1:0]        src_state,
  input  logic [qlgs_pkg::STATE_W-1:0]        dst_state,
  input  logic [qlgs_pkg::RAND_W-1:0]         rand_value,
  input  logic                                cfg_valid,
  input  logic [qlgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qlgs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [qlgs_pkg::STATE_W-1:0]        cur_state,
  output logic [qlgs_pkg::QOUT_W-1:0]         q_value,
  output logic                                episode_done,
  output logic                                no_move_error
);

  localparam int NS       = qlgs_pkg::NUM_STATES;
  localparam int SW       = qlgs_pkg::STATE_W;
  localparam int AW       = 2 * qlgs_pkg::STATE_W;
  localparam int IX       = qlgs_pkg::IDX_W;
  localparam int RW       = RATE_FRAC_BITS + 1;
  localparam int CW       = (RW > 9) ? RW : 9;
  localparam int TW       = ((Q_WIDTH > 24) ? Q_WIDTH : 24) + 1;
  localparam int QX       = (Q_WIDTH > 32) ? Q_WIDTH : 32;
  localparam int RATE_ONE = 1 << RATE_FRAC_BITS;
  localparam logic [TW:0] QMAX_T = {{(TW + 1 - Q_WIDTH){1'b0}}, {Q_WIDTH{1'b1}}};

  function automatic logic [AW-1:0] qaddr(input logic [SW-1:0] r, input logic [SW-1:0] c);
    return AW'(r) * AW'(NS) + AW'(c);
  endfunction

  function automatic logic [RW-1:0] clamp(input logic [8:0] r);
    logic [CW-1:0] e;
    e = CW'(r);
    if (e > CW'(RATE_ONE)) return RW'(RATE_ONE);
    return RW'(e);
  endfunction

  // Configuration registers.
  logic [8:0]  learning_rate;
  logic [8:0]  discount_rate;
  logic [3:0]  goal_idx;
  logic [15:0] reward_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= 9'd128;
      discount_rate <= 9'd205;
      goal_idx      <= 4'd0;
      reward_value  <= 16'd100;
    end else if (cfg_valid) begin
      unique case (qlgs_pkg::cfg_reg_t'(cfg_index))
        qlgs_pkg::CFG_LEARNING_RATE: learning_rate <= cfg_data[8:0];
        qlgs_pkg::CFG_DISCOUNT_RATE: discount_rate <= cfg_data[8:0];
        qlgs_pkg::CFG_GOAL_STATE:    goal_idx      <= cfg_data[3:0];
        qlgs_pkg::CFG_REWARD_VALUE:  reward_value  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured item.
  qlgs_pkg::action_t act;
  logic [IX-1:0]     src7, dst7;
  logic [31:0]       rnd;
  logic              idx_ok;
  logic [SW-1:0]     src_i, dst_i;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act  <= qlgs_pkg::action_t'(action);
      src7 <= IX'(src_state);
      dst7 <= IX'(dst_state);
      rnd  <= rand_value;
    end
  end

  assign idx_ok = (src7 < IX'(NS)) && (dst7 < IX'(NS));
  assign src_i  = src7[SW-1:0];
  assign dst_i  = dst7[SW-1:0];

  // Clearing pass counter.
  logic [AW-1:0] clr;
  logic          clr_last;

  assign clr_last = (clr == AW'(NS * NS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clr_wr) begin
      clr <= clr + AW'(1);
    end
  end

  // Edge memory.
  logic [NS-1:0] edge_mem [NS];
  logic [NS-1:0] edge_rdata;
  logic [NS-1:0] row;
  logic [SW-1:0] present;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      if (clr < AW'(NS)) edge_mem[clr[SW-1:0]] <= '0;
    end else if (cmd.ewr && idx_ok) begin
      edge_mem[src_i] <= edge_rdata | (NS'(1) << dst_i);
    end
    if (cmd.erd) edge_rdata <= edge_mem[cmd.erd_src ? src_i : present];
  end

  // Scan counters.
  logic [SW-1:0] j;
  logic [IX-1:0] cnt, seen;
  logic [SW-1:0] nxt;
  logic          hit;
  logic          mod_done;
  logic [IX-1:0] mod_rem;

  assign hit = row[j] && (seen == mod_rem);

  always_ff @(posedge clk) begin
    if (cmd.row_load) row <= edge_rdata;
    if (cmd.j_clr) begin
      j <= '0;
    end else if (cmd.cnt_step || cmd.pick_step || cmd.max_issue) begin
      j <= j + SW'(1);
    end
    if (cmd.row_load) begin
      cnt <= '0;
    end else if (cmd.cnt_step) begin
      cnt <= cnt + IX'(row[j]);
    end
    if (cmd.row_load) begin
      seen <= '0;
    end else if (cmd.pick_step && row[j]) begin
      if (seen == mod_rem) nxt <= j;
      else seen <= seen + IX'(1);
    end
  end

  qlgs_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (rnd),
    .divisor  (cnt),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Q memory.
  logic [Q_WIDTH-1:0] q_mem [NS * NS];
  logic [Q_WIDTH-1:0] q_rdata;
  logic [AW-1:0]      q_raddr;
  logic [Q_WIDTH-1:0] qnew;

  always_comb begin
    unique case (cmd.q_sel)
      qlgs_pkg::QA_SN: q_raddr = qaddr(present, nxt);
      qlgs_pkg::QA_RQ: q_raddr = qaddr(src_i, dst_i);
      default:         q_raddr = qaddr(nxt, j);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      q_mem[clr] <= '0;
    end else if (cmd.upd) begin
      q_mem[qaddr(present, nxt)] <= qnew;
    end
    if (cmd.q_rd) q_rdata <= q_mem[q_raddr];
  end

  // Row maximum and update arithmetic.
  logic                    rd_vld;
  logic [Q_WIDTH-1:0]      maxq, qsn;
  logic [RW+Q_WIDTH-1:0]   prod1;
  logic [TW-1:0]           target, diff, inc;
  logic                    neg;
  logic [RW+TW-1:0]        prod2;
  logic [TW:0]             sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.max_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.j_clr) begin
      maxq <= '0;
    end else if (rd_vld && (q_rdata > maxq)) begin
      maxq <= q_rdata;
    end
    if (cmd.mul1) begin
      prod1 <= (RW + Q_WIDTH)'(clamp(discount_rate)) * (RW + Q_WIDTH)'(maxq);
      qsn   <= q_rdata;
    end
    if (cmd.tgt) begin
      target <= ((IX'(nxt) == IX'(goal_idx)) ? (TW'(reward_value) << qlgs_pkg::Q_FRAC) : '0)
                + TW'(prod1 >> RATE_FRAC_BITS);
    end
    if (cmd.diff) begin
      if (target >= TW'(qsn)) begin
        neg  <= 1'b0;
        diff <= target - TW'(qsn);
      end else begin
        neg  <= 1'b1;
        diff <= TW'(qsn) - target;
      end
    end
    if (cmd.mul2) prod2 <= (RW + TW)'(clamp(learning_rate)) * (RW + TW)'(diff);
  end

  assign inc  = TW'(prod2 >> RATE_FRAC_BITS);
  assign sum  = neg ? ((TW + 1)'(qsn) - (TW + 1)'(inc)) : ((TW + 1)'(qsn) + (TW + 1)'(inc));
  assign qnew = (sum > QMAX_T) ? {Q_WIDTH{1'b1}} : sum[Q_WIDTH-1:0];

  // Result and present state.
  logic [Q_WIDTH-1:0] res_q;
  logic               res_done, res_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (cmd.set_start) begin
      present <= rnd[SW-1:0];
    end else if (cmd.upd) begin
      present <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_q    <= '0;
      res_done <= 1'b0;
      res_err  <= 1'b0;
    end else begin
      if (cmd.set_err) res_err <= 1'b1;
      if (cmd.set_rq) res_q <= idx_ok ? q_rdata : '0;
      if (cmd.upd) begin
        res_q    <= qnew;
        res_done <= (IX'(goal_idx) == IX'(present));
      end
    end
  end

  // Output register.
  logic [Q_WIDTH-1:0] out_q;
  logic [IX-1:0]      pres7;
  logic [QX-1:0]      qx;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pres7         <= IX'(present);
      out_q         <= res_q;
      episode_done  <= res_done;
      no_move_error <= res_err;
    end
  end

  assign qx        = QX'(out_q);
  assign q_value   = qx[qlgs_pkg::QOUT_W-1:0];
  assign cur_state = pres7[qlgs_pkg::STATE_W-1:0];

  assign sts.clr_last = clr_last;
  assign sts.act      = act;
  assign sts.j_last   = (j == SW'(NS - 1));
  assign sts.cnt_zero = (cnt == '0);
  assign sts.mod_done = mod_done;
  assign sts.hit      = hit;
  assign sts.out_free = !out_valid || out_ready;

endmodule
